// File: rtl/ebr_pkg.sv
// ebr_pkg: field widths, codes, controller states and the command and status
// groups shared by the eigen bend reconstruction modules
// no dependencies
package ebr_pkg;

    // payload and register widths
    localparam int OPC_W      = 2;
    localparam int EIG_W      = 32;
    localparam int VEC_W      = 18;
    localparam int ENTRY_W    = 48;
    localparam int ROW_W      = 3;
    localparam int SIZE_W     = 4;
    localparam int THR_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic [SIZE_W-1:0]       SIZE_RESET = 4'd8;
    localparam logic signed [THR_W-1:0] THR_RESET  = 32'sd50;

    // the exact sum carries 56 fraction bits, the result 24
    localparam int RES_SHIFT = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEND_THRESHOLD = 1'b1;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD_EIGEN  = 2'd0,
        OP_LOAD_VECTOR = 2'd1,
        OP_COMPUTE     = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BEND,
        ST_MAC,
        ST_WAIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic ld_eigen;
        logic ld_vector;
        logic clr_index;
        logic bend_step;
        logic mac_step;
        logic mac_first;
        logic mac_last;
        logic entry_last;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic entry_pushed;
    } dp_status_t;

endpackage

// File: rtl/ebr_ctrl.sv
// ebr_ctrl: sequencer for loads, the bend pass and the row/column/k sweep
// depends on ebr_pkg
module ebr_ctrl
    import ebr_pkg::*;
#(
    parameter int MAX_ORDER = 8,
    parameter int KW        = $clog2(MAX_ORDER),
    parameter int NW        = $clog2(MAX_ORDER + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [OPC_W-1:0] s_opcode,
    input  logic [NW-1:0]    order_n,
    input  dp_status_t       status,
    output dp_cmd_t          cmd,
    output logic [KW-1:0]    idx_i,
    output logic [KW-1:0]    idx_j,
    output logic [KW-1:0]    idx_k
);

    ctrl_state_t state_reg, state_next;
    logic [KW-1:0] i_reg, i_next;
    logic [KW-1:0] j_reg, j_next;
    logic [KW-1:0] k_reg, k_next;
    logic          accept;
    logic          last_i, last_j, last_k;

    assign accept = s_valid && s_ready;
    assign last_i = (NW'(i_reg) == order_n - NW'(1));
    assign last_j = (NW'(j_reg) == order_n - NW'(1));
    assign last_k = (NW'(k_reg) == order_n - NW'(1));

    assign idx_i = i_reg;
    assign idx_j = j_reg;
    assign idx_k = k_reg;

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_opcode == OP_COMPUTE) begin
                    state_next = ST_BEND;
                    k_next     = '0;
                end
            end
            ST_BEND: begin
                if (last_k) begin
                    state_next = ST_MAC;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_MAC: begin
                if (last_k) begin
                    state_next = ST_WAIT;
                    k_next     = '0;
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_WAIT: begin
                if (status.entry_pushed) begin
                    if (last_i && last_j) begin
                        state_next = ST_IDLE;
                    end else if (last_j) begin
                        state_next = ST_MAC;
                        j_next     = '0;
                        i_next     = i_reg + KW'(1);
                    end else begin
                        state_next = ST_MAC;
                        j_next     = j_reg + KW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.entry_last = last_i && last_j;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.ld_eigen  = accept && s_opcode == OP_LOAD_EIGEN;
                cmd.ld_vector = accept && s_opcode == OP_LOAD_VECTOR;
                cmd.clr_index = accept && s_opcode == OP_COMPUTE;
            end
            ST_BEND: begin
                cmd.bend_step = 1'b1;
            end
            ST_MAC: begin
                cmd.mac_step  = 1'b1;
                cmd.mac_first = (k_reg == '0);
                cmd.mac_last  = last_k;
            end
            ST_WAIT: begin
                cmd.mac_step = 1'b0;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/ebr_datapath.sv
// ebr_datapath: eigenvalue and vector stores, bend pass, shared multiply-
// accumulate pipe, rounding and the output register
// depends on ebr_pkg
module ebr_datapath
    import ebr_pkg::*;
#(
    parameter int MAX_ORDER = 8,
    parameter int KW        = $clog2(MAX_ORDER),
    parameter int NW        = $clog2(MAX_ORDER + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    input  logic [KW-1:0]             idx_i,
    input  logic [KW-1:0]             idx_j,
    input  logic [KW-1:0]             idx_k,
    input  logic [NW-1:0]             order_n,
    input  logic signed [THR_W-1:0]   bend_threshold,
    input  logic signed [EIG_W-1:0]   s_eigen_value,
    input  logic signed [VEC_W-1:0]   s_vector_entry,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ENTRY_W-1:0] m_entry_value,
    output logic [ROW_W-1:0]          m_row,
    output logic [ROW_W-1:0]          m_column,
    output logic                      m_last
);

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = $clog2(DEPTH);
    localparam int AW1   = AW + 1;
    localparam int NNW   = $clog2(DEPTH + 1);
    localparam int GW    = $clog2(MAX_ORDER);
    localparam int PROD_W = 2 * VEC_W;
    localparam int HP_W  = PROD_W + 16;
    localparam int LP_W  = PROD_W + 17;
    localparam int HA_W  = HP_W + GW;
    localparam int LA_W  = LP_W + GW;
    localparam int SUM_W = HA_W + 17;

    // stores
    logic signed [EIG_W-1:0] eig_reg  [MAX_ORDER];
    logic signed [EIG_W-1:0] bent_reg [MAX_ORDER];
    logic signed [VEC_W-1:0] vec_mem  [DEPTH];
    logic signed [EIG_W-1:0] prev_reg;

    logic [KW-1:0]  eig_idx_reg, eig_idx_next, eig_wr_idx;
    logic [AW-1:0]  vec_idx_reg, vec_idx_next, vec_wr_idx;
    logic [NNW-1:0] order_nn;

    // pipe
    logic                     v0_reg, f0_reg, l0_reg;
    logic                     v1_reg, f1_reg, l1_reg;
    logic                     v2_reg, f2_reg, l2_reg;
    logic signed [VEC_W-1:0]  rd_a_reg, rd_b_reg;
    logic signed [EIG_W-1:0]  d_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [15:0]       dh_reg;
    logic [15:0]              dl_reg;
    logic signed [HP_W-1:0]   hp_reg;
    logic signed [LP_W-1:0]   lp_reg;
    logic signed [HA_W-1:0]   hi_acc_reg;
    logic signed [LA_W-1:0]   lo_acc_reg;
    logic                     round_go_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     res_pend_reg;
    logic                     m_valid_reg;
    logic signed [ENTRY_W-1:0] m_entry_value_reg;
    logic [ROW_W-1:0]         m_row_reg, m_column_reg;
    logic                     m_last_reg;

    logic [AW-1:0]            addr_a, addr_b;
    logic [AW1-1:0]           addr_a_full, addr_b_full;
    logic signed [EIG_W-1:0]  bend_in, bend_out;
    logic                     push;

    // load index wrap, restarting when the order was lowered
    always_comb begin
        order_nn   = NNW'(order_n) * NNW'(order_n);
        eig_wr_idx = (NW'(eig_idx_reg) >= order_n) ? '0 : eig_idx_reg;
        eig_idx_next = (NW'(eig_wr_idx) + NW'(1) >= order_n) ? '0
                                                             : eig_wr_idx + KW'(1);
        vec_wr_idx = (NNW'(vec_idx_reg) >= order_nn) ? '0 : vec_idx_reg;
        vec_idx_next = (NNW'(vec_wr_idx) + NNW'(1) >= order_nn) ? '0
                                                                : vec_wr_idx + AW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eig_idx_reg <= '0;
            vec_idx_reg <= '0;
        end else if (cmd.clr_index) begin
            eig_idx_reg <= '0;
            vec_idx_reg <= '0;
        end else begin
            if (cmd.ld_eigen) begin
                eig_idx_reg <= eig_idx_next;
            end
            if (cmd.ld_vector) begin
                vec_idx_reg <= vec_idx_next;
            end
        end
    end

    // eigenvalue store and bend pass
    assign bend_in  = eig_reg[idx_k];
    assign bend_out = (idx_k != '0 && bend_in < bend_threshold) ? prev_reg : bend_in;

    always_ff @(posedge aclk) begin
        if (cmd.ld_eigen) begin
            eig_reg[eig_wr_idx] <= s_eigen_value;
        end
        if (cmd.bend_step) begin
            bent_reg[idx_k] <= bend_out;
            prev_reg        <= bend_out;
        end
    end

    // vector memory, one write port and two registered read ports
    assign addr_a_full = AW1'(idx_i) * AW1'(order_n) + AW1'(idx_k);
    assign addr_b_full = AW1'(idx_j) * AW1'(order_n) + AW1'(idx_k);
    assign addr_a      = addr_a_full[AW-1:0];
    assign addr_b      = addr_b_full[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.ld_vector) begin
            vec_mem[vec_wr_idx] <= s_vector_entry;
        end
        if (cmd.mac_step) begin
            rd_a_reg <= vec_mem[addr_a];
            rd_b_reg <= vec_mem[addr_b];
            d_reg    <= bent_reg[idx_k];
        end
    end

    // pipe control bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            round_go_reg <= 1'b0;
        end else begin
            v0_reg       <= cmd.mac_step;
            v1_reg       <= v0_reg;
            v2_reg       <= v1_reg;
            round_go_reg <= v2_reg && l2_reg;
        end
    end

    // product, split eigenvalue products, accumulation and rounding sum
    always_ff @(posedge aclk) begin
        f0_reg <= cmd.mac_first;
        l0_reg <= cmd.mac_last;
        f1_reg <= f0_reg;
        l1_reg <= l0_reg;
        f2_reg <= f1_reg;
        l2_reg <= l1_reg;

        prod_reg <= rd_a_reg * rd_b_reg;
        dh_reg   <= d_reg[EIG_W-1:16];
        dl_reg   <= d_reg[15:0];

        hp_reg <= prod_reg * dh_reg;
        lp_reg <= prod_reg * $signed({1'b0, dl_reg});

        if (v2_reg) begin
            hi_acc_reg <= f2_reg ? HA_W'(hp_reg) : hi_acc_reg + HA_W'(hp_reg);
            lo_acc_reg <= f2_reg ? LA_W'(lp_reg) : lo_acc_reg + LA_W'(lp_reg);
        end

        // round to nearest, ties up: add half an output unit before the shift
        if (round_go_reg) begin
            sum_reg <= (SUM_W'(hi_acc_reg) <<< 16) + SUM_W'(lo_acc_reg)
                       + (SUM_W'(1) <<< (RES_SHIFT - 1));
        end
    end

    // result slot and output register
    assign push                = res_pend_reg && (!m_valid_reg || m_ready);
    assign status.entry_pushed = push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (round_go_reg) begin
                res_pend_reg <= 1'b1;
            end else if (push) begin
                res_pend_reg <= 1'b0;
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // the shifted sum is narrower than the entry, so saturation never bites
    always_ff @(posedge aclk) begin
        if (push) begin
            m_entry_value_reg <= ENTRY_W'($signed(sum_reg[SUM_W-1:RES_SHIFT]));
            m_row_reg         <= ROW_W'(idx_i);
            m_column_reg      <= ROW_W'(idx_j);
            m_last_reg        <= cmd.entry_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_entry_value = m_entry_value_reg;
    assign m_row         = m_row_reg;
    assign m_column      = m_column_reg;
    assign m_last        = m_last_reg;

    // loads only arrive with the pipe and result slot empty
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ld_eigen || cmd.ld_vector) |->
            !(v0_reg || v1_reg || v2_reg || round_go_reg || res_pend_reg))
        else $error("load while the accumulate pipe is busy");

    // a finished sum always lands in the result slot
    a_round_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        round_go_reg |=> res_pend_reg)
        else $error("rounded sum lost");

    // a waiting result keeps its value until it moves out
    a_pend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_pend_reg && !push) |=> (res_pend_reg && $stable(sum_reg)))
        else $error("pending result changed before hand-over");

    // a hand-over fills the output register with the right end marker
    a_push_out: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (m_valid_reg && m_last_reg == $past(cmd.entry_last)))
        else $error("output register not loaded on hand-over");

endmodule

// File: rtl/eigen_bend_reconstruct.sv
// eigen_bend_reconstruct: top level, configuration registers and the
// controller and datapath instances; depends on ebr_pkg, ebr_ctrl, ebr_datapath
//
// channel | direction | handshake        | payload
// cfg     | in        | cfg_we           | cfg_index, cfg_wdata
// s       | in        | s_valid/s_ready  | s_opcode, s_eigen_value, s_vector_entry
// m       | out       | m_valid/m_ready  | m_entry_value, m_row, m_column, m_last
//
// a compute beat that is taken starts the bend pass over the n eigenvalues and then
// one multiply-accumulate pass per matrix entry, n*n entries, one entry at a time
// through the single shared multiply-accumulate pipe
// reset is synchronous and active low; no clearing pass is needed
// a stalled m side holds the current entry and pauses the entry sweep;
// s_ready drops from a compute beat until the last entry sits in the output
module eigen_bend_reconstruct
    import ebr_pkg::*;
#(
    parameter int MAX_ORDER = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OPC_W-1:0]          s_opcode,
    input  logic signed [EIG_W-1:0]   s_eigen_value,
    input  logic signed [VEC_W-1:0]   s_vector_entry,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ENTRY_W-1:0] m_entry_value,
    output logic [ROW_W-1:0]          m_row,
    output logic [ROW_W-1:0]          m_column,
    output logic                      m_last
);

    localparam int KW = $clog2(MAX_ORDER);
    localparam int NW = $clog2(MAX_ORDER + 1);

    logic [SIZE_W-1:0]       matrix_size_reg;
    logic signed [THR_W-1:0] bend_threshold_reg;
    logic [NW-1:0]           order_n;
    dp_cmd_t                 cmd;
    dp_status_t              status;
    logic [KW-1:0]           idx_i, idx_j, idx_k;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_size_reg    <= SIZE_RESET;
            bend_threshold_reg <= THR_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MATRIX_SIZE:    matrix_size_reg    <= cfg_wdata[SIZE_W-1:0];
                CFG_BEND_THRESHOLD: bend_threshold_reg <= $signed(cfg_wdata[THR_W-1:0]);
                default:            matrix_size_reg    <= matrix_size_reg;
            endcase
        end
    end

    // order in use: zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (matrix_size_reg == '0) begin
            order_n = NW'(1);
        end else if (SIZE_W'(matrix_size_reg) > SIZE_W'(MAX_ORDER)) begin
            order_n = NW'(MAX_ORDER);
        end else begin
            order_n = matrix_size_reg[NW-1:0];
        end
    end

    ebr_ctrl #(
        .MAX_ORDER (MAX_ORDER),
        .KW        (KW),
        .NW        (NW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .order_n  (order_n),
        .status   (status),
        .cmd      (cmd),
        .idx_i    (idx_i),
        .idx_j    (idx_j),
        .idx_k    (idx_k)
    );

    ebr_datapath #(
        .MAX_ORDER (MAX_ORDER),
        .KW        (KW),
        .NW        (NW)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .idx_i          (idx_i),
        .idx_j          (idx_j),
        .idx_k          (idx_k),
        .order_n        (order_n),
        .bend_threshold (bend_threshold_reg),
        .s_eigen_value  (s_eigen_value),
        .s_vector_entry (s_vector_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_entry_value  (m_entry_value),
        .m_row          (m_row),
        .m_column       (m_column),
        .m_last         (m_last)
    );

endmodule

// File: tb/ebr_tb_pkg.sv
`timescale 1ns / 1ps
// ebr_tb_pkg: matrix entry record and the scoreboard that mirrors the eigen bend
// reconstruction and checks every entry beat; depends on ebr_pkg
package ebr_tb_pkg;
    import ebr_pkg::*;

    localparam int MAX_N = 8;
    localparam int ACC_W = 80;

    // opcode that the block ignores
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    // rounding and saturation bounds on the wide accumulator
    localparam logic signed [ACC_W-1:0] ACC_HALF     = 80'sd1 <<< (RES_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] ENTRY_TOP    = (80'sd1 <<< (ENTRY_W - 1)) - 80'sd1;
    localparam logic signed [ACC_W-1:0] ENTRY_BOTTOM = -(80'sd1 <<< (ENTRY_W - 1));

    typedef struct {
        logic signed [ENTRY_W-1:0] value;
        logic [ROW_W-1:0]          row;
        logic [ROW_W-1:0]          column;
        logic                      last;
    } matrix_entry_t;

    class ebr_matrix_scoreboard;
        logic [SIZE_W-1:0]       size_reg;
        logic signed [THR_W-1:0] floor_reg;
        logic signed [EIG_W-1:0] eigen_mem [MAX_N];
        logic signed [VEC_W-1:0] vector_mem [MAX_N*MAX_N];
        bit                      eigen_seen [MAX_N];
        bit                      vector_seen [MAX_N*MAX_N];
        int                      eigen_ptr;
        int                      vector_ptr;
        matrix_entry_t           entries_due [$];
        int unsigned             fail_count;

        function new();
            size_reg   = SIZE_RESET;
            floor_reg  = THR_RESET;
            eigen_ptr  = 0;
            vector_ptr = 0;
            fail_count = 0;
            foreach (eigen_seen[k]) eigen_seen[k] = 1'b0;
            foreach (vector_seen[k]) vector_seen[k] = 1'b0;
        endfunction

        function void write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MATRIX_SIZE:    size_reg = data[SIZE_W-1:0];
                CFG_BEND_THRESHOLD: floor_reg = data[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // order in use: zero acts as one, oversize clips to the maximum
        function int order();
            if (size_reg == 0)
                return 1;
            if (size_reg > MAX_N)
                return MAX_N;
            return int'(size_reg);
        endfunction

        // true when a compute would only read entries loaded since reset
        function bit can_compute();
            int n;
            n = order();
            for (int k = 0; k < n; k++)
                if (!eigen_seen[k])
                    return 1'b0;
            for (int k = 0; k < n * n; k++)
                if (!vector_seen[k])
                    return 1'b0;
            return 1'b1;
        endfunction

        function int unsigned pending();
            return entries_due.size();
        endfunction

        // one accepted input beat
        function void absorb_command(logic [OPC_W-1:0] op, logic signed [EIG_W-1:0] eig,
                                     logic signed [VEC_W-1:0] vec);
            int n;
            n = order();
            case (op)
                OP_LOAD_EIGEN: begin
                    if (eigen_ptr >= n)
                        eigen_ptr = 0;
                    eigen_mem[eigen_ptr]  = eig;
                    eigen_seen[eigen_ptr] = 1'b1;
                    eigen_ptr = (eigen_ptr + 1 >= n) ? 0 : eigen_ptr + 1;
                end
                OP_LOAD_VECTOR: begin
                    if (vector_ptr >= n * n)
                        vector_ptr = 0;
                    vector_mem[vector_ptr]  = vec;
                    vector_seen[vector_ptr] = 1'b1;
                    vector_ptr = (vector_ptr + 1 >= n * n) ? 0 : vector_ptr + 1;
                end
                OP_COMPUTE: begin
                    reconstruct_matrix();
                    eigen_ptr  = 0;
                    vector_ptr = 0;
                end
                default: ;
            endcase
        endfunction

        // bend the eigenvalues, then queue V diag(d) V^T row by row
        function void reconstruct_matrix();
            logic signed [EIG_W-1:0] bent [MAX_N];
            logic signed [ACC_W-1:0] acc;
            logic signed [ACC_W-1:0] pair_x;
            logic signed [ACC_W-1:0] eig_x;
            longint                  pair;
            int                      n;
            matrix_entry_t           ent;
            n = order();
            for (int k = 0; k < n; k++) begin
                bent[k] = eigen_mem[k];
                if (k > 0 && eigen_mem[k] < floor_reg)
                    bent[k] = bent[k-1];
            end
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    acc = '0;
                    for (int k = 0; k < n; k++) begin
                        pair   = longint'(vector_mem[i*n+k]) * longint'(vector_mem[j*n+k]);
                        pair_x = ACC_W'(pair);
                        eig_x  = ACC_W'(bent[k]);
                        acc    = acc + pair_x * eig_x;
                    end
                    // nearest, ties upward, then clamp
                    acc = (acc + ACC_HALF) >>> RES_SHIFT;
                    if (acc > ENTRY_TOP)
                        acc = ENTRY_TOP;
                    if (acc < ENTRY_BOTTOM)
                        acc = ENTRY_BOTTOM;
                    ent.value  = acc[ENTRY_W-1:0];
                    ent.row    = ROW_W'(i);
                    ent.column = ROW_W'(j);
                    ent.last   = (i == n - 1) && (j == n - 1);
                    entries_due.push_back(ent);
                end
            end
        endfunction

        // one accepted result beat against the oldest expected entry
        function void check_entry(logic signed [ENTRY_W-1:0] value, logic [ROW_W-1:0] row,
                                  logic [ROW_W-1:0] column, logic last);
            matrix_entry_t want;
            if (entries_due.size() == 0) begin
                $error("entry beat with nothing expected: row %0d column %0d value %0d",
                       row, column, value);
                fail_count++;
                return;
            end
            want = entries_due.pop_front();
            if (value !== want.value) begin
                $error("entry_value: expected %0d, actual %0d", want.value, value);
                fail_count++;
            end
            if (row !== want.row) begin
                $error("row: expected %0d, actual %0d", want.row, row);
                fail_count++;
            end
            if (column !== want.column) begin
                $error("column: expected %0d, actual %0d", want.column, column);
                fail_count++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, last);
                fail_count++;
            end
        endfunction
    endclass

endpackage

// File: tb/tb_eigen_bend_reconstruct.sv
`timescale 1ns / 1ps
// tb_eigen_bend_reconstruct: directed and random load/compute traffic with random
// stalls on both channels, entries checked by the scoreboard; needs ebr_pkg, ebr_tb_pkg
module tb_eigen_bend_reconstruct;
    import ebr_pkg::*;
    import ebr_tb_pkg::*;

    localparam int          RANDOM_BEATS  = 330;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          HOLD_CYCLES   = 1000;
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    localparam logic signed [EIG_W-1:0] EIG_TOP    = 32'sh7fff_ffff;
    localparam logic signed [EIG_W-1:0] EIG_BOTTOM = 32'sh8000_0000;
    localparam logic signed [VEC_W-1:0] VEC_TOP    = 18'sh1_ffff;
    localparam logic signed [VEC_W-1:0] VEC_BOTTOM = 18'sh2_0000;
    localparam logic signed [EIG_W-1:0] EIG_ONE    = 32'sh0100_0000;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    logic [OPC_W-1:0]          s_opcode;
    logic signed [EIG_W-1:0]   s_eigen_value;
    logic signed [VEC_W-1:0]   s_vector_entry;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [ENTRY_W-1:0] m_entry_value;
    logic [ROW_W-1:0]          m_row;
    logic [ROW_W-1:0]          m_column;
    logic                      m_last;

    ebr_matrix_scoreboard sb;
    bit                   no_idle;
    bit                   hold_request;
    int                   beats_sent;

    eigen_bend_reconstruct #(
        .MAX_ORDER(MAX_N)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_eigen_value (s_eigen_value),
        .s_vector_entry(s_vector_entry),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_entry_value (m_entry_value),
        .m_row         (m_row),
        .m_column      (m_column),
        .m_last        (m_last)
    );

    // clock
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb_eigen_bend_reconstruct NOT OK");
        $finish;
    end

    // result beat monitor
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            sb.check_entry(m_entry_value, m_row, m_column, m_last);
    end

    // result side ready, with random stalls and one long hold-off
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
        end
    end

    // one input beat: random gap, then hold until accepted
    task automatic send_beat(input logic [OPC_W-1:0] op, input logic signed [EIG_W-1:0] eig,
                             input logic signed [VEC_W-1:0] vec);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_opcode       <= op;
        s_eigen_value  <= eig;
        s_vector_entry <= vec;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.absorb_command(op, eig, vec);
        if (op != OP_UNUSED)
            beats_sent++;
    endtask

    // lower valid, wait for every expected entry, then let the block go quiet
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.write_config(idx, data);
    endtask

    // eigenvalue mix: extremes, values around the floor, anything
    function automatic logic signed [EIG_W-1:0] pick_eigen();
        longint near;
        near = longint'(sb.floor_reg) + longint'($urandom_range(0, 200)) - 100;
        if (near > EIG_TOP)
            near = EIG_TOP;
        if (near < EIG_BOTTOM)
            near = EIG_BOTTOM;
        case ($urandom_range(0, 9))
            0:       return EIG_TOP;
            1:       return EIG_BOTTOM;
            2, 3:    return near[EIG_W-1:0];
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [VEC_W-1:0] pick_vector();
        case ($urandom_range(0, 9))
            0:       return VEC_TOP;
            1:       return VEC_BOTTOM;
            2:       return '0;
            default: return VEC_W'($urandom);
        endcase
    endfunction

    // mostly small orders, a few at the top and out of range
    function automatic logic [SIZE_W-1:0] pick_matrix_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return SIZE_W'($urandom_range(1, 3));
        if (r < 78)
            return SIZE_W'($urandom_range(4, 5));
        if (r < 92)
            return SIZE_W'($urandom_range(6, 7));
        if (r < 95)
            return SIZE_W'(8);
        if (r < 97)
            return '0;
        return SIZE_W'($urandom_range(9, 15));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        case ($urandom_range(0, 7))
            0:          return EIG_BOTTOM;
            1:          return EIG_TOP;
            2:          return THR_RESET;
            3, 4, 5:    return int'($urandom_range(0, 33554432)) - 16777216;
            default:    return $urandom;
        endcase
    endfunction

    // register settings per phase: fixed settings first, then random
    task automatic configure_phase(input int phase);
        case (phase)
            0: begin
                write_register(CFG_MATRIX_SIZE, 8);
                write_register(CFG_BEND_THRESHOLD, THR_RESET);
            end
            1: begin
                write_register(CFG_MATRIX_SIZE, 15);
                write_register(CFG_BEND_THRESHOLD, EIG_TOP);
            end
            2: begin
                write_register(CFG_MATRIX_SIZE, 0);
                write_register(CFG_BEND_THRESHOLD, EIG_BOTTOM);
            end
            3: begin
                write_register(CFG_MATRIX_SIZE, 3);
                write_register(CFG_BEND_THRESHOLD, 0);
            end
            default: begin
                if ($urandom_range(0, 1))
                    write_register(CFG_MATRIX_SIZE, CFG_DATA_W'(pick_matrix_size()));
                if ($urandom_range(0, 1))
                    write_register(CFG_BEND_THRESHOLD, pick_threshold());
            end
        endcase
    endtask

    // whole load set and compute, or a ragged run of loads and noise that may end in a compute
    task automatic run_episode(input bit whole, input bit with_hold);
        int n;
        int cnt;
        int r;
        n = sb.order();
        if (whole) begin
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(OP_UNUSED, $urandom, VEC_W'($urandom));
                send_beat(OP_LOAD_EIGEN, pick_eigen(), VEC_W'($urandom));
            end
            for (int k = 0; k < n * n; k++) begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(OP_UNUSED, $urandom, VEC_W'($urandom));
                send_beat(OP_LOAD_VECTOR, $urandom, pick_vector());
            end
            if (with_hold)
                hold_request = 1'b1;
            send_beat(OP_COMPUTE, $urandom, VEC_W'($urandom));
        end else begin
            cnt = $urandom_range(0, 2 * n + 2);
            repeat (cnt) begin
                r = $urandom_range(0, 9);
                if (r < 4)
                    send_beat(OP_LOAD_EIGEN, pick_eigen(), VEC_W'($urandom));
                else if (r < 9)
                    send_beat(OP_LOAD_VECTOR, $urandom, pick_vector());
                else
                    send_beat(OP_UNUSED, $urandom, VEC_W'($urandom));
            end
            if (sb.can_compute() && $urandom_range(0, 4) != 0)
                send_beat(OP_COMPUTE, $urandom, VEC_W'($urandom));
        end
    endtask

    // main sequence
    initial begin
        int phase;
        sb             = new();
        no_idle        = 1'b0;
        hold_request   = 1'b0;
        beats_sent     = 0;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_MATRIX_SIZE;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_opcode       = OP_LOAD_EIGEN;
        s_eigen_value  = '0;
        s_vector_entry = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // order one: extreme products of both signs, ignored opcode, index wrap
        write_register(CFG_MATRIX_SIZE, 1);
        send_beat(OP_LOAD_EIGEN, EIG_TOP, VEC_W'($urandom));
        send_beat(OP_LOAD_VECTOR, $urandom, VEC_BOTTOM);
        send_beat(OP_COMPUTE, $urandom, VEC_W'($urandom));
        send_beat(OP_LOAD_EIGEN, EIG_BOTTOM, VEC_W'($urandom));
        send_beat(OP_LOAD_VECTOR, $urandom, VEC_TOP);
        send_beat(OP_COMPUTE, $urandom, VEC_W'($urandom));
        send_beat(OP_UNUSED, $urandom, VEC_W'($urandom));
        send_beat(OP_LOAD_EIGEN, 123, VEC_W'($urandom));

        // order two: second eigenvalue under the floor takes the first
        settle_block();
        write_register(CFG_MATRIX_SIZE, 2);
        send_beat(OP_LOAD_EIGEN, EIG_ONE, '0);
        send_beat(OP_LOAD_EIGEN, 10, '0);
        send_beat(OP_LOAD_VECTOR, '0, VEC_TOP);
        send_beat(OP_LOAD_VECTOR, '0, VEC_BOTTOM);
        send_beat(OP_LOAD_VECTOR, '0, '0);
        send_beat(OP_LOAD_VECTOR, '0, 18'sd32768);
        send_beat(OP_COMPUTE, '0, '0);

        // first eigenvalue under the floor is kept, the next copies it
        send_beat(OP_LOAD_EIGEN, -5, '0);
        send_beat(OP_LOAD_EIGEN, EIG_BOTTOM, '0);
        send_beat(OP_COMPUTE, '0, '0);

        // leave both load indices past the end of a smaller order
        send_beat(OP_LOAD_EIGEN, EIG_ONE, '0);
        send_beat(OP_LOAD_VECTOR, '0, 18'sd1000);
        send_beat(OP_LOAD_VECTOR, '0, -18'sd777);
        send_beat(OP_LOAD_VECTOR, '0, 18'sd4321);
        settle_block();
        write_register(CFG_MATRIX_SIZE, 1);
        send_beat(OP_LOAD_EIGEN, 32'sh0080_0000, '0);
        send_beat(OP_LOAD_VECTOR, '0, -18'sd65536);
        send_beat(OP_COMPUTE, '0, '0);

        // random phases, register changes only between them
        beats_sent = 0;
        phase      = 0;
        while (beats_sent < RANDOM_BEATS) begin
            settle_block();
            configure_phase(phase);
            no_idle = (phase > 0) && ($urandom_range(0, 4) == 0);
            if (phase == 0) begin
                run_episode(1'b1, 1'b1);
                run_episode(1'b0, 1'b0);
            end else begin
                repeat ($urandom_range(1, 3))
                    if (beats_sent < RANDOM_BEATS)
                        run_episode($urandom_range(0, 3) != 0, 1'b0);
            end
            phase++;
        end

        settle_block();
        if (sb.pending() != 0) begin
            $error("%0d expected entries never arrived", sb.pending());
            sb.fail_count++;
        end
        if (sb.fail_count == 0)
            $display("tb_eigen_bend_reconstruct OK");
        else
            $display("tb_eigen_bend_reconstruct NOT OK");
        $finish;
    end

endmodule

// File: eigen_bend_reconstruct.f
rtl/ebr_pkg.sv
rtl/ebr_ctrl.sv
rtl/ebr_datapath.sv
rtl/eigen_bend_reconstruct.sv
tb/ebr_tb_pkg.sv
tb/tb_eigen_bend_reconstruct.sv
